// ----- hw/rtl/aabb_frustum_cull_core_defines.svh -----
// Assertion macros for the box-versus-frustum cull core.
// Depends on nothing; taken in by the top level with `include.
`ifndef AABB_FRUSTUM_CULL_CORE_DEFINES_SVH
`define AABB_FRUSTUM_CULL_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define AFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cull core check failed");

// Next-cycle implication, disabled while reset is asserted
`define AFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cull core check failed");

`endif

// ----- hw/rtl/afc_pkg.sv -----
// Shared types and constants of the box-versus-frustum cull core.
// No dependencies; used by the interfaces and every module.
package afc_pkg;

  localparam int NumPlanes = 6;
  localparam int NumAxes   = 3;
  localparam int NumStages = 4;
  localparam int CoordW    = 16;
  localparam int ExtW      = 15;
  localparam int PlaneW    = 64;
  localparam int CfgIdxW   = 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [ExtW-1:0]   ext_t;
  typedef logic        [PlaneW-1:0] plane_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    PlaneLeft   = 3'd0,
    PlaneRight  = 3'd1,
    PlaneTop    = 3'd2,
    PlaneBottom = 3'd3,
    PlaneNear   = 3'd4,
    PlaneFar    = 3'd5
  } plane_idx_e;

  // Per-stage load enables and valid bits of the pipeline
  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } pipe_t;

endpackage

// ----- hw/rtl/afc_ifs.sv -----
// Valid/ready channel interfaces: box input, visibility result, register writes.
// Depends on afc_pkg.
interface afc_box_if;
  logic            valid;
  logic            ready;
  afc_pkg::coord_t center_x;
  afc_pkg::coord_t center_y;
  afc_pkg::coord_t center_z;
  afc_pkg::ext_t   extent_x;
  afc_pkg::ext_t   extent_y;
  afc_pkg::ext_t   extent_z;
  modport source (output valid, center_x, center_y, center_z, extent_x, extent_y, extent_z,
                  input ready);
  modport sink   (input valid, center_x, center_y, center_z, extent_x, extent_y, extent_z,
                  output ready);
endinterface

interface afc_res_if;
  logic valid;
  logic ready;
  logic visible;
  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

interface afc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [afc_pkg::CfgIdxW-1:0] index;
  afc_pkg::plane_t             data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/aabb_frustum_cull_core.sv -----
// Box-versus-frustum cull core: one box per cycle sustained while results are taken;
// in each plane lane the multipliers sit in the first stage and the wide adds in the second and third.
// The input stalls only when all four stages are full and the result is not taken.
// rst_ni (asynchronous, active low) empties the pipeline and clears all six planes,
// so every box reads as visible until planes are written. Register writes are taken
// every cycle.
`include "aabb_frustum_cull_core_defines.svh"

module aabb_frustum_cull_core (
  input logic       clk_i,
  input logic       rst_ni,
  afc_box_if.sink   box_i,
  afc_res_if.source res_o,
  afc_cfg_if.sink   cfg_i
);

  afc_pkg::plane_t plane_q [afc_pkg::NumPlanes];
  afc_pkg::pipe_t  ctrl;
  afc_pkg::coord_t center [afc_pkg::NumAxes];
  afc_pkg::ext_t   extent [afc_pkg::NumAxes];
  logic [afc_pkg::NumPlanes-1:0] pass;
  logic            visible_q;
  logic            cfg_we;

  // Plane registers, written by index
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < afc_pkg::NumPlanes; i++) begin
        plane_q[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_i.index)
        afc_pkg::PlaneLeft:   plane_q[0] <= cfg_i.data;
        afc_pkg::PlaneRight:  plane_q[1] <= cfg_i.data;
        afc_pkg::PlaneTop:    plane_q[2] <= cfg_i.data;
        afc_pkg::PlaneBottom: plane_q[3] <= cfg_i.data;
        afc_pkg::PlaneNear:   plane_q[4] <= cfg_i.data;
        afc_pkg::PlaneFar:    plane_q[5] <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // Pipeline control
  afc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (box_i.valid),
    .out_ready_i (res_o.ready),
    .in_ready_o  (box_i.ready),
    .ctrl_o      (ctrl)
  );

  assign center[0] = box_i.center_x;
  assign center[1] = box_i.center_y;
  assign center[2] = box_i.center_z;
  assign extent[0] = box_i.extent_x;
  assign extent[1] = box_i.extent_y;
  assign extent[2] = box_i.extent_z;

  // One lane per plane
  for (genvar p = 0; p < afc_pkg::NumPlanes; p++) begin : g_lane
    afc_plane_lane u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .plane_i  (plane_q[p]),
      .center_i (center),
      .extent_i (extent),
      .pass_o   (pass[p])
    );
  end

  // Stage 4: visible only when every plane passes
  always_ff @(posedge clk_i) begin
    if (ctrl.en[3]) begin
      visible_q <= &pass;
    end
  end

  assign res_o.valid   = ctrl.vld[3];
  assign res_o.visible = visible_q;

  // Checks
  `AFC_ASSERT_NOW(a_stall_only_when_out_blocked, clk_i, rst_ni, !box_i.ready, res_o.valid && !res_o.ready)
  `AFC_ASSERT_NEXT(a_accept_fills_first_stage, clk_i, rst_ni, box_i.valid && box_i.ready, ctrl.vld[0])
  `AFC_ASSERT_NEXT(a_drain_drops_one, clk_i, rst_ni, res_o.valid && res_o.ready && !(box_i.valid && box_i.ready), $countones(ctrl.vld) + 1 == $past($countones(ctrl.vld)))

endmodule

// ----- hw/rtl/afc_pipe_ctrl.sv -----
// Valid bits and stall chain of the four-stage cull pipeline.
// Depends on afc_pkg.
module afc_pipe_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_ready_i,
  output logic           in_ready_o,
  output afc_pkg::pipe_t ctrl_o
);

  logic [afc_pkg::NumStages-1:0] vld_q, vld_d;
  logic [afc_pkg::NumStages-1:0] rdy;

  // A stage may load when it is empty or its content moves on
  always_comb begin
    rdy[afc_pkg::NumStages-1] = !vld_q[afc_pkg::NumStages-1] || out_ready_i;
    for (int k = afc_pkg::NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  // Advance valid bits alongside the data
  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < afc_pkg::NumStages; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = rdy[0];
  assign ctrl_o.en  = rdy;
  assign ctrl_o.vld = vld_q;

endmodule

// ----- hw/rtl/afc_plane_lane.sv -----
// One plane test over three stages: products, radius and distance sums, sign test.
// Depends on afc_pkg.
module afc_plane_lane (
  input  logic            clk_i,
  input  afc_pkg::pipe_t  ctrl_i,
  input  afc_pkg::plane_t plane_i,
  input  afc_pkg::coord_t center_i [afc_pkg::NumAxes],
  input  afc_pkg::ext_t   extent_i [afc_pkg::NumAxes],
  output logic            pass_o
);

  afc_pkg::coord_t    nrm [afc_pkg::NumAxes];
  logic [15:0]        nrm_abs [afc_pkg::NumAxes];
  logic signed [31:0] nc_q [afc_pkg::NumAxes];
  logic [30:0]        ne_q [afc_pkg::NumAxes];
  afc_pkg::coord_t    dist_q;
  logic [31:0]        r_q, r_d;
  logic signed [34:0] d_q, d_d;
  logic signed [35:0] slack;
  logic               pass_q;

  // Unpack normal; the most negative code maps to 2.0 exactly
  always_comb begin
    for (int i = 0; i < afc_pkg::NumAxes; i++) begin
      nrm[i]     = plane_i[16*i +: 16];
      nrm_abs[i] = nrm[i][15] ? (~nrm[i] + 16'd1) : nrm[i];
    end
  end

  // Stage 1: two multipliers per axis, one for distance and one for radius
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      for (int i = 0; i < afc_pkg::NumAxes; i++) begin
        nc_q[i] <= 32'(nrm[i]) * 32'(center_i[i]);
        ne_q[i] <= nrm_abs[i] * extent_i[i];
      end
      dist_q <= plane_i[63:48];
    end
  end

  // Stage 2: sum the products and take off dist scaled to Q14
  always_comb begin
    r_d = 32'(ne_q[0]) + 32'(ne_q[1]) + 32'(ne_q[2]);
    d_d = 35'(nc_q[0]) + 35'(nc_q[1]) + 35'(nc_q[2])
        - $signed({{5{dist_q[15]}}, dist_q, 14'b0});
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      r_q <= r_d;
      d_q <= d_d;
    end
  end

  // Stage 3: plane passes when d + r is not negative
  assign slack = 36'(d_q) + $signed({4'b0000, r_q});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      pass_q <= !slack[35];
    end
  end

  assign pass_o = pass_q;

endmodule
